// ===== sv/pose_point_transform_unit_assert.svh =====
// Assertion macros shared by the checkers of the pose transform unit.
// Each macro names the clock and reset of the scope in which it is used.
`ifndef POSE_POINT_TRANSFORM_UNIT_ASSERT_SVH
`define POSE_POINT_TRANSFORM_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define PPTU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pose transform check failed");

// Antecedent implies consequent in the next cycle.
`define PPTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pose transform check failed");

`endif

// ===== sv/ppt_pkg.sv =====
package ppt_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int QUAT_W    = 16;
    localparam int ROT_W     = 18;
    localparam int ROT_FRAC  = 14;
    localparam int PROD_W    = DIFF_W + ROT_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int QPROD_W   = 2 * QUAT_W;
    localparam int RAW_W     = QPROD_W + 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int INT_W     = 16;

    // The matrix is rebuilt through a product register and a matrix register.
    localparam int REBUILD_CYCLES = 2;
    localparam int REBUILD_CNT_W  = $clog2(REBUILD_CYCLES + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION = 3'd0,
        CFG_POS_X     = 3'd1,
        CFG_POS_Y     = 3'd2,
        CFG_POS_Z     = 3'd3,
        CFG_QUAT_W    = 3'd4,
        CFG_QUAT_X    = 3'd5,
        CFG_QUAT_Y    = 3'd6,
        CFG_QUAT_Z    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
    } quat_t;

    typedef struct packed {
        logic                      dir;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } pose_cfg_t;

    typedef logic signed [ROT_W-1:0] rot_entry_t;
    // Entry r*3+c holds row r, column c.
    typedef rot_entry_t [8:0] rot_mat_t;

    typedef struct packed {
        logic                      sat;
        logic signed [COORD_W-1:0] val;
    } coord_res_t;

    localparam logic signed [QUAT_W-1:0]  QUAT_ONE = QUAT_W'(1 << ROT_FRAC);
    localparam logic signed [QUAT_W-1:0]  QUAT_ZERO = '0;
    localparam rot_entry_t ROT_ONE  = ROT_W'(1 << ROT_FRAC);
    localparam rot_entry_t ROT_ZERO = '0;
    localparam rot_entry_t ROT_MAX  = {1'b0, {(ROT_W-1){1'b1}}};
    localparam rot_entry_t ROT_MIN  = {1'b1, {(ROT_W-1){1'b0}}};
    localparam rot_mat_t   ROT_IDENT = {ROT_ONE, ROT_ZERO, ROT_ZERO,
                                        ROT_ZERO, ROT_ONE, ROT_ZERO,
                                        ROT_ZERO, ROT_ZERO, ROT_ONE};
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Round half up by ROT_FRAC bits and clamp to the matrix entry range.
    function automatic rot_entry_t rot_round(input logic signed [RAW_W-1:0] raw);
        logic signed [RAW_W-1:0]          rnd;
        logic signed [RAW_W-ROT_FRAC-1:0] sh;
        rot_entry_t                       res;
        rnd = raw + RAW_W'(1 << (ROT_FRAC - 1));
        sh  = rnd[RAW_W-1:ROT_FRAC];
        if (sh > ROT_MAX)
        begin
            res = ROT_MAX;
        end
        else if (sh < ROT_MIN)
        begin
            res = ROT_MIN;
        end
        else
        begin
            res = sh[ROT_W-1:0];
        end
        return res;
    endfunction

    // Round half up by ROT_FRAC bits and clamp to the coordinate range.
    function automatic coord_res_t coord_round(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0]          rnd;
        logic signed [ACC_W-ROT_FRAC-1:0] sh;
        coord_res_t                       res;
        rnd = acc + ACC_W'(1 << (ROT_FRAC - 1));
        sh  = rnd[ACC_W-1:ROT_FRAC];
        if (sh > COORD_MAX)
        begin
            res.sat = 1'b1;
            res.val = COORD_MAX;
        end
        else if (sh < COORD_MIN)
        begin
            res.sat = 1'b1;
            res.val = COORD_MIN;
        end
        else
        begin
            res.sat = 1'b0;
            res.val = sh[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/ppt_rot_build.sv =====
module ppt_rot_build
    import ppt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  quat_t    quat,
    output rot_mat_t rot_mat
);

    localparam logic signed [RAW_W-1:0] RAW_ONE = RAW_W'(1) << (2 * ROT_FRAC);

    logic signed [QPROD_W-1:0] xx_reg, yy_reg, zz_reg;
    logic signed [QPROD_W-1:0] xy_reg, xz_reg, yz_reg;
    logic signed [QPROD_W-1:0] wx_reg, wy_reg, wz_reg;

    logic signed [RAW_W-1:0] e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
    logic signed [RAW_W-1:0] raw [9];
    rot_mat_t                rot_mat_reg, rot_mat_next;

    // The products follow the quaternion registers every cycle, so after any
    // quaternion write the matrix settles once the product and matrix registers have loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xx_reg <= '0;
            yy_reg <= '0;
            zz_reg <= '0;
            xy_reg <= '0;
            xz_reg <= '0;
            yz_reg <= '0;
            wx_reg <= '0;
            wy_reg <= '0;
            wz_reg <= '0;
        end
        else
        begin
            xx_reg <= quat.x * quat.x;
            yy_reg <= quat.y * quat.y;
            zz_reg <= quat.z * quat.z;
            xy_reg <= quat.x * quat.y;
            xz_reg <= quat.x * quat.z;
            yz_reg <= quat.y * quat.z;
            wx_reg <= quat.w * quat.x;
            wy_reg <= quat.w * quat.y;
            wz_reg <= quat.w * quat.z;
        end
    end

    always_comb
    begin
        e_xx = RAW_W'(xx_reg);
        e_yy = RAW_W'(yy_reg);
        e_zz = RAW_W'(zz_reg);
        e_xy = RAW_W'(xy_reg);
        e_xz = RAW_W'(xz_reg);
        e_yz = RAW_W'(yz_reg);
        e_wx = RAW_W'(wx_reg);
        e_wy = RAW_W'(wy_reg);
        e_wz = RAW_W'(wz_reg);

        raw[0] = RAW_ONE - ((e_yy + e_zz) <<< 1);
        raw[1] = (e_xy - e_wz) <<< 1;
        raw[2] = (e_xz + e_wy) <<< 1;
        raw[3] = (e_xy + e_wz) <<< 1;
        raw[4] = RAW_ONE - ((e_xx + e_zz) <<< 1);
        raw[5] = (e_yz - e_wx) <<< 1;
        raw[6] = (e_xz - e_wy) <<< 1;
        raw[7] = (e_yz + e_wx) <<< 1;
        raw[8] = RAW_ONE - ((e_xx + e_yy) <<< 1);

        for (int k = 0; k < 9; k++)
        begin
            rot_mat_next[k] = rot_round(raw[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_mat_reg <= ROT_IDENT;
        end
        else
        begin
            rot_mat_reg <= rot_mat_next;
        end
    end

    assign rot_mat = rot_mat_reg;

endmodule

// ===== sv/ppt_xform_pipe.sv =====
module ppt_xform_pipe
    import ppt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  pose_cfg_t                 pose,
    input  rot_mat_t                  rot_mat,
    input  logic                      hold,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    input  logic [INT_W-1:0]          point_intensity,
    input  logic                      point_last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic signed [COORD_W-1:0] out_z,
    output logic [INT_W-1:0]          out_intensity,
    output logic                      out_last,
    output logic                      out_saturated
);

    logic ld1, ld2, ld3, accept;

    logic                     s1_valid_reg;
    logic signed [DIFF_W-1:0] s1_c_reg [3];
    logic signed [DIFF_W-1:0] s1_c_next [3];
    logic [INT_W-1:0]         s1_int_reg;
    logic                     s1_last_reg;

    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_prod_reg [3][3];
    logic signed [PROD_W-1:0] s2_prod_next [3][3];
    logic [INT_W-1:0]         s2_int_reg;
    logic                     s2_last_reg;

    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] out_c_reg [3];
    logic [INT_W-1:0]          out_int_reg;
    logic                      out_last_reg;
    logic                      out_sat_reg;

    logic signed [DIFF_W-1:0]  p [3];
    logic signed [DIFF_W-1:0]  t [3];
    logic signed [COORD_W-1:0] pos [3];
    rot_entry_t                m;
    logic signed [ACC_W-1:0]   acc;
    coord_res_t                res [3];

    // Each stage loads when it is empty or when the stage after it loads.
    assign ld3      = !out_valid_reg || !out_stall;
    assign ld2      = !s2_valid_reg || ld3;
    assign ld1      = !s1_valid_reg || ld2;
    assign in_stall = !ld1 || hold;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                s1_valid_reg <= accept;
            end
            if (ld2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ld3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Input stage: global to local subtracts the translation before rotating.
    always_comb
    begin
        pos[0] = pose.pos_x;
        pos[1] = pose.pos_y;
        pos[2] = pose.pos_z;
        p[0]   = DIFF_W'(point_x);
        p[1]   = DIFF_W'(point_y);
        p[2]   = DIFF_W'(point_z);
        for (int j = 0; j < 3; j++)
        begin
            t[j]         = DIFF_W'(pos[j]);
            s1_c_next[j] = pose.dir ? (p[j] - t[j]) : p[j];
        end
    end

    // Product stage: the transpose is taken by swapping row and column.
    always_comb
    begin
        m = ROT_ZERO;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                m = pose.dir ? rot_mat[j*3 + i] : rot_mat[i*3 + j];
                s2_prod_next[i][j] = PROD_W'(s1_c_reg[j]) * PROD_W'(m);
            end
        end
    end

    // Sum stage: translation enters here only for local to global.
    always_comb
    begin
        acc = '0;
        for (int i = 0; i < 3; i++)
        begin
            acc = ACC_W'(s2_prod_reg[i][0]) + ACC_W'(s2_prod_reg[i][1])
                + ACC_W'(s2_prod_reg[i][2])
                + (pose.dir ? ACC_W'(0) : (ACC_W'(pos[i]) <<< ROT_FRAC));
            res[i] = coord_round(acc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && accept)
        begin
            s1_c_reg    <= s1_c_next;
            s1_int_reg  <= point_intensity;
            s1_last_reg <= point_last;
        end
        if (ld2 && s1_valid_reg)
        begin
            s2_prod_reg <= s2_prod_next;
            s2_int_reg  <= s1_int_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (ld3 && s2_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_c_reg[i] <= res[i].val;
            end
            out_sat_reg  <= res[0].sat | res[1].sat | res[2].sat;
            out_int_reg  <= s2_int_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_x         = out_c_reg[0];
    assign out_y         = out_c_reg[1];
    assign out_z         = out_c_reg[2];
    assign out_intensity = out_int_reg;
    assign out_last      = out_last_reg;
    assign out_saturated = out_sat_reg;

endmodule

// ===== sv/pose_point_transform_unit.sv =====
// Rigid pose transform for a stream of 3D points in signed fixed point.
// Configuration: a write channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// sets the direction, the translation and the Q2.14 quaternion. cfg_ready is
// always high. Writes must be made only while no point is in flight; the block
// itself does not enforce this. A quaternion write rebuilds the rotation
// matrix; the input channel stalls while the matrix is rebuilt.
// Points: a word enters on in_valid with in_stall low and leaves on out_valid
// with out_stall low. The stages are the input register, one rank of 18 bit
// by 33 bit multipliers, then the adder, rounding and clamp into the output
// register; one point is taken every cycle unless the input stalls. Each
// stage moves on its own, so bubbles close up while the receiver stalls, and
// back-pressure stalls the input only once all three stages are full; a
// matrix rebuild also stalls it. A stalled result holds its value.
// Reset clears the pipeline, sets direction to local to global, translation
// to zero and the quaternion to identity, and loads the identity matrix.
module pose_point_transform_unit
    import ppt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    input  logic [INT_W-1:0]          point_intensity,
    input  logic                      point_last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic signed [COORD_W-1:0] out_z,
    output logic [INT_W-1:0]          out_intensity,
    output logic                      out_last,
    output logic                      out_saturated
);

    pose_cfg_t                pose_reg, pose_next;
    quat_t                    quat_reg, quat_next;
    logic [REBUILD_CNT_W-1:0] rebuild_cnt_reg, rebuild_cnt_next;
    logic                     cfg_wr;
    logic                     quat_wr;
    rot_mat_t                 rot_mat;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        pose_next = pose_reg;
        quat_next = quat_reg;
        quat_wr   = 1'b0;
        if (cfg_wr)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DIRECTION: pose_next.dir   = cfg_data[0];
                CFG_POS_X:     pose_next.pos_x = cfg_data[COORD_W-1:0];
                CFG_POS_Y:     pose_next.pos_y = cfg_data[COORD_W-1:0];
                CFG_POS_Z:     pose_next.pos_z = cfg_data[COORD_W-1:0];
                CFG_QUAT_W:
                begin
                    quat_next.w = cfg_data[QUAT_W-1:0];
                    quat_wr     = 1'b1;
                end
                CFG_QUAT_X:
                begin
                    quat_next.x = cfg_data[QUAT_W-1:0];
                    quat_wr     = 1'b1;
                end
                CFG_QUAT_Y:
                begin
                    quat_next.y = cfg_data[QUAT_W-1:0];
                    quat_wr     = 1'b1;
                end
                CFG_QUAT_Z:
                begin
                    quat_next.z = cfg_data[QUAT_W-1:0];
                    quat_wr     = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        if (quat_wr)
        begin
            rebuild_cnt_next = REBUILD_CNT_W'(REBUILD_CYCLES);
        end
        else if (rebuild_cnt_reg != '0)
        begin
            rebuild_cnt_next = rebuild_cnt_reg - 1'b1;
        end
        else
        begin
            rebuild_cnt_next = rebuild_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_reg.dir    <= 1'b0;
            pose_reg.pos_x  <= '0;
            pose_reg.pos_y  <= '0;
            pose_reg.pos_z  <= '0;
            quat_reg.w      <= QUAT_ONE;
            quat_reg.x      <= QUAT_ZERO;
            quat_reg.y      <= QUAT_ZERO;
            quat_reg.z      <= QUAT_ZERO;
            rebuild_cnt_reg <= '0;
        end
        else
        begin
            pose_reg        <= pose_next;
            quat_reg        <= quat_next;
            rebuild_cnt_reg <= rebuild_cnt_next;
        end
    end

    ppt_rot_build u_rot_build (
        .clk     (clk),
        .rst_n   (rst_n),
        .quat    (quat_reg),
        .rot_mat (rot_mat)
    );

    ppt_xform_pipe u_xform_pipe (
        .clk             (clk),
        .rst_n           (rst_n),
        .pose            (pose_reg),
        .rot_mat         (rot_mat),
        .hold            (rebuild_cnt_reg != '0),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .point_x         (point_x),
        .point_y         (point_y),
        .point_z         (point_z),
        .point_intensity (point_intensity),
        .point_last      (point_last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_z           (out_z),
        .out_intensity   (out_intensity),
        .out_last        (out_last),
        .out_saturated   (out_saturated)
    );

endmodule

// ===== sv/ppt_checker.sv =====
`include "pose_point_transform_unit_assert.svh"

module ppt_checker
    import ppt_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [CFG_IDX_W-1:0]      cfg_index,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [COORD_W-1:0] out_x,
    input logic signed [COORD_W-1:0] out_y,
    input logic signed [COORD_W-1:0] out_z,
    input logic                      out_last
);

    logic quat_write;

    assign quat_write = cfg_valid && cfg_ready
                     && (cfg_index == CFG_QUAT_W || cfg_index == CFG_QUAT_X
                      || cfg_index == CFG_QUAT_Y || cfg_index == CFG_QUAT_Z);

    // A stalled result word keeps its value.
    `PPTU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(out_last))

    // No point enters while the rotation matrix is being rebuilt.
    `PPTU_ASSERT_IMPL(a_rebuild_stall, quat_write, ##1 in_stall ##1 in_stall)

    // With the receiver taking words, an accepted point reaches the output stage.
    `PPTU_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall, out_valid)

endmodule

bind pose_point_transform_unit ppt_checker u_ppt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_last  (out_last)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ppt_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 120;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 100;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [INT_W-1:0]          intensity;
        logic                      last;
        logic                      sat;
    } point_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [INT_W-1:0]          point_intensity;
    logic                      point_last;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [INT_W-1:0]          out_intensity;
    logic                      out_last;
    logic                      out_saturated;

    // Mirror of the pose held by the block.
    logic                      pose_dir;
    logic signed [COORD_W-1:0] pose_t [3];
    quat_t                     pose_q;
    rot_entry_t                rot_mat [9];

    point_result_t             expected_points [$];
    int                        errors = 0;
    int                        cycle_count = 0;
    bit                        idle_en = 1'b1;
    bit                        stall_en = 1'b1;
    int                        hold_requests = 0;
    int                        hold_seen = 0;
    int                        hold_left = 0;

    pose_point_transform_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .point_x         (point_x),
        .point_y         (point_y),
        .point_z         (point_z),
        .point_intensity (point_intensity),
        .point_last      (point_last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_z           (out_z),
        .out_intensity   (out_intensity),
        .out_last        (out_last),
        .out_saturated   (out_saturated)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("pose_point_transform_unit regression: fail");
        $finish;
    end

    // Receiver: random stalls, plus long hold-offs requested by the tests.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= stall_en && ($urandom_range(0, 99) < 10);
        end
    end

    task automatic report_mismatch(input string msg);
        if (errors < PRINT_LIMIT)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        errors++;
    endtask

    function automatic longint round_q14(input longint v);
        return (v + (longint'(1) <<< (ROT_FRAC - 1))) >>> ROT_FRAC;
    endfunction

    function automatic void rebuild_rotation();
        longint w;
        longint x;
        longint y;
        longint z;
        longint one;
        longint raw [9];
        longint v;
        w = $signed(pose_q.w);
        x = $signed(pose_q.x);
        y = $signed(pose_q.y);
        z = $signed(pose_q.z);
        one = longint'(1) <<< (2 * ROT_FRAC);
        raw[0] = one - 2 * (y * y + z * z);
        raw[1] = 2 * (x * y - w * z);
        raw[2] = 2 * (x * z + w * y);
        raw[3] = 2 * (x * y + w * z);
        raw[4] = one - 2 * (x * x + z * z);
        raw[5] = 2 * (y * z - w * x);
        raw[6] = 2 * (x * z - w * y);
        raw[7] = 2 * (y * z + w * x);
        raw[8] = one - 2 * (x * x + y * y);
        for (int k = 0; k < 9; k++)
        begin
            v = round_q14(raw[k]);
            if (v > longint'(ROT_MAX))
            begin
                rot_mat[k] = ROT_MAX;
            end
            else if (v < longint'(ROT_MIN))
            begin
                rot_mat[k] = ROT_MIN;
            end
            else
            begin
                rot_mat[k] = v[ROT_W-1:0];
            end
        end
    endfunction

    function automatic void reset_pose_model();
        pose_dir = 1'b0;
        pose_t[0] = '0;
        pose_t[1] = '0;
        pose_t[2] = '0;
        pose_q.w = QUAT_ONE;
        pose_q.x = QUAT_ZERO;
        pose_q.y = QUAT_ZERO;
        pose_q.z = QUAT_ZERO;
        rebuild_rotation();
    endfunction

    function automatic void apply_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DIRECTION: pose_dir = data[0];
            CFG_POS_X:     pose_t[0] = data;
            CFG_POS_Y:     pose_t[1] = data;
            CFG_POS_Z:     pose_t[2] = data;
            CFG_QUAT_W:
            begin
                pose_q.w = data[QUAT_W-1:0];
                rebuild_rotation();
            end
            CFG_QUAT_X:
            begin
                pose_q.x = data[QUAT_W-1:0];
                rebuild_rotation();
            end
            CFG_QUAT_Y:
            begin
                pose_q.y = data[QUAT_W-1:0];
                rebuild_rotation();
            end
            CFG_QUAT_Z:
            begin
                pose_q.z = data[QUAT_W-1:0];
                rebuild_rotation();
            end
            default: ;
        endcase
    endfunction

    // R*p + t, or R^T*(p - t) for the inverse pose, rounded and clamped.
    function automatic point_result_t transform_point(
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic signed [COORD_W-1:0] z,
        input logic [INT_W-1:0]          intensity,
        input logic                      last
    );
        longint        p [3];
        longint        t [3];
        longint        acc;
        logic signed [COORD_W-1:0] c [3];
        point_result_t r;
        p[0] = x;
        p[1] = y;
        p[2] = z;
        r.sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            t[i] = pose_t[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            if (pose_dir)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    acc += longint'(rot_mat[j * 3 + i]) * (p[j] - t[j]);
                end
            end
            else
            begin
                for (int j = 0; j < 3; j++)
                begin
                    acc += longint'(rot_mat[i * 3 + j]) * p[j];
                end
                acc += t[i] <<< ROT_FRAC;
            end
            acc = round_q14(acc);
            if (acc > longint'(COORD_MAX))
            begin
                acc = COORD_MAX;
                r.sat = 1'b1;
            end
            else if (acc < longint'(COORD_MIN))
            begin
                acc = COORD_MIN;
                r.sat = 1'b1;
            end
            c[i] = acc[COORD_W-1:0];
        end
        r.x = c[0];
        r.y = c[1];
        r.z = c[2];
        r.intensity = intensity;
        r.last = last;
        return r;
    endfunction

    task automatic check_point(input point_result_t want);
        if (out_x !== want.x)
            report_mismatch($sformatf("out_x got %h expected %h", out_x, want.x));
        if (out_y !== want.y)
            report_mismatch($sformatf("out_y got %h expected %h", out_y, want.y));
        if (out_z !== want.z)
            report_mismatch($sformatf("out_z got %h expected %h", out_z, want.z));
        if (out_intensity !== want.intensity)
            report_mismatch($sformatf("out_intensity got %h expected %h",
                                      out_intensity, want.intensity));
        if (out_last !== want.last)
            report_mismatch($sformatf("out_last got %b expected %b", out_last, want.last));
        if (out_saturated !== want.sat)
            report_mismatch($sformatf("out_saturated got %b expected %b",
                                      out_saturated, want.sat));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_points.size() == 0)
            begin
                report_mismatch("result word with no point outstanding");
            end
            else
            begin
                check_point(expected_points.pop_front());
            end
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        apply_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Unused upper data bits get random junk; the block must ignore them.
    task automatic set_pose(
        input logic                      dir,
        input logic signed [COORD_W-1:0] tx,
        input logic signed [COORD_W-1:0] ty,
        input logic signed [COORD_W-1:0] tz,
        input quat_t                     q
    );
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom;
        write_reg(CFG_DIRECTION, {junk[CFG_DATA_W-1:1], dir});
        write_reg(CFG_POS_X, tx);
        write_reg(CFG_POS_Y, ty);
        write_reg(CFG_POS_Z, tz);
        junk = $urandom;
        write_reg(CFG_QUAT_W, {junk[CFG_DATA_W-1:QUAT_W], q.w});
        write_reg(CFG_QUAT_X, {junk[QUAT_W-1:0], q.x});
        junk = $urandom;
        write_reg(CFG_QUAT_Y, {junk[CFG_DATA_W-1:QUAT_W], q.y});
        write_reg(CFG_QUAT_Z, {junk[QUAT_W-1:0], q.z});
    endtask

    task automatic send_point(
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic signed [COORD_W-1:0] z,
        input logic [INT_W-1:0]          intensity,
        input logic                      last
    );
        @(negedge clk);
        while (idle_en && ($urandom_range(0, 99) < 10))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        point_x         <= x;
        point_y         <= y;
        point_z         <= z;
        point_intensity <= intensity;
        point_last      <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        expected_points.insert(expected_points.size(),
                               transform_point(x, y, z, intensity, last));
    endtask

    // Config may only change once every point has left the block.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [COORD_W-1:0] random_coord();
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom;
        end
        return int'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
    endfunction

    function automatic quat_t make_quat(input int w, input int x, input int y, input int z);
        quat_t q;
        q.w = w[QUAT_W-1:0];
        q.x = x[QUAT_W-1:0];
        q.y = y[QUAT_W-1:0];
        q.z = z[QUAT_W-1:0];
        return q;
    endfunction

    function automatic quat_t random_unit_quat();
        real a [4];
        real n;
        for (int k = 0; k < 4; k++)
        begin
            a[k] = real'(int'($urandom_range(0, 2000))) - 1000.0;
        end
        n = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
        if (n < 1.0)
        begin
            return make_quat(16384, 0, 0, 0);
        end
        return make_quat($rtoi(a[0] / n * 16384.0), $rtoi(a[1] / n * 16384.0),
                         $rtoi(a[2] / n * 16384.0), $rtoi(a[3] / n * 16384.0));
    endfunction

    function automatic logic random_last();
        return ($urandom_range(0, 7) == 0);
    endfunction

    // Pose right out of reset must be the identity.
    task automatic test_reset_identity();
        send_point(COORD_MAX, COORD_MIN, 0, 16'hFFFF, 1'b1);
        send_point(COORD_MIN, COORD_MAX, -1, 16'h0000, 1'b0);
        send_point(0, 0, 0, 16'hAAAA, 1'b0);
        send_point(-1, 1, 32'h5555_5555, 16'h5555, 1'b1);
        wait_idle();
    endtask

    task automatic test_translation_saturation();
        set_pose(1'b0, COORD_MAX, COORD_MIN, 32'sd0, make_quat(16384, 0, 0, 0));
        send_point(1, -1, 0, 16'h1234, 1'b0);
        send_point(COORD_MIN, COORD_MAX, 12345, 16'h8001, 1'b1);
        wait_idle();
        set_pose(1'b1, COORD_MAX, COORD_MIN, 32'sd1, make_quat(16384, 0, 0, 0));
        send_point(COORD_MIN, COORD_MAX, 0, 16'h00FF, 1'b0);
        send_point(COORD_MAX, COORD_MIN, COORD_MIN, 16'hFF00, 1'b1);
        wait_idle();
    endtask

    task automatic test_rotation_cases();
        // Half turn about z with the largest legal component.
        set_pose(1'b0, 32'sd7, -32'sd3, 32'sd0, make_quat(0, 0, 0, 16384));
        send_point(32'sd12345, -32'sd999, COORD_MAX, 16'h0F0F, 1'b0);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 16'hF0F0, 1'b1);
        wait_idle();
        // Quarter turn with inexact entries: rounding lands on halves.
        set_pose(1'b1, 32'sd8192, -32'sd8192, 32'sd1, make_quat(11585, 0, 0, 11585));
        send_point(32'sd3, 32'sd8191, -32'sd8193, 16'h0001, 1'b0);
        send_point(32'sd1, -32'sd1, 32'sd16384, 16'h8000, 1'b0);
        send_point(32'sh0001_0000, 32'sh7FFF_0000, -32'sh0000_8000, 16'h7FFF, 1'b1);
        wait_idle();
        // Non-unit quaternion, matrix stays in range.
        set_pose(1'b0, 32'sd0, 32'sd0, 32'sd0, make_quat(16384, 16384, 16384, 16384));
        send_point(32'sh0100_0000, -32'sh0200_0000, 32'sh0300_0000, 16'h3C3C, 1'b0);
        send_point(32'sd77, -32'sd5, 32'sd123456, 16'hC3C3, 1'b1);
        wait_idle();
        // Raw quaternion outside its range: matrix entries clamp.
        set_pose(1'b1, 32'sd100, 32'sd0, -32'sd100, make_quat(-32768, -32768, -32768, -32768));
        send_point(32'sh0001_0000, 32'sh0002_0000, -32'sh0001_0000, 16'h0102, 1'b0);
        send_point(COORD_MAX, COORD_MIN, COORD_MAX, 16'h0201, 1'b1);
        wait_idle();
        set_pose(1'b0, 32'sd0, 32'sd0, 32'sd0, make_quat(32767, 32767, 32767, 32767));
        send_point(32'sd65536, 32'sd65536, 32'sd65536, 16'h4242, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_poses();
        logic                      dir;
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
        logic signed [COORD_W-1:0] tz;
        quat_t                     q;
        for (int ph = 0; ph < 10; ph++)
        begin
            dir = ph[0];
            tx = random_coord();
            ty = random_coord();
            tz = random_coord();
            if (ph == 2)
            begin
                tx = COORD_MAX;
                ty = COORD_MAX;
                tz = COORD_MAX;
            end
            else if (ph == 3)
            begin
                tx = COORD_MIN;
                ty = COORD_MIN;
                tz = COORD_MIN;
            end
            if (ph == 4)
            begin
                q = make_quat($urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), $urandom_range(0, 65535));
            end
            else if (ph == 5)
            begin
                q = make_quat(-16384, 0, 0, 0);
            end
            else
            begin
                q = random_unit_quat();
            end
            set_pose(dir, tx, ty, tz, q);
            // One phase runs with both sides streaming flat out.
            idle_en  = (ph != 6);
            stall_en = (ph != 6);
            for (int n = 0; n < 90; n++)
            begin
                send_point(random_coord(), random_coord(), random_coord(),
                           $urandom_range(0, 65535), random_last());
            end
            wait_idle();
        end
        idle_en  = 1'b1;
        stall_en = 1'b1;
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall the input.
    task automatic test_back_pressure();
        set_pose(1'b0, random_coord(), random_coord(), random_coord(), random_unit_quat());
        idle_en = 1'b0;
        hold_requests++;
        for (int n = 0; n < 40; n++)
        begin
            send_point(random_coord(), random_coord(), random_coord(),
                       $urandom_range(0, 65535), random_last());
        end
        idle_en = 1'b1;
        wait_idle();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_DIRECTION;
        cfg_data        = '0;
        in_valid        = 1'b0;
        point_x         = '0;
        point_y         = '0;
        point_z         = '0;
        point_intensity = '0;
        point_last      = 1'b0;
        reset_pose_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_identity();
        test_translation_saturation();
        test_rotation_cases();
        test_random_poses();
        test_back_pressure();

        if (errors == 0)
        begin
            $display("pose_point_transform_unit regression: pass");
        end
        else
        begin
            $display("pose_point_transform_unit regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/ppt_pkg.sv
sv/ppt_rot_build.sv
sv/ppt_xform_pipe.sv
sv/pose_point_transform_unit.sv
sv/ppt_checker.sv
dv/testbench.sv
